// ----- hdl/tmhs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmhs_pkg
// Types, codes and constants shared by the timer min-heap scheduler.
// ----------------------------------------------------------------------------
package tmhs_pkg;

  localparam int HeapDepthDefault = 16;
  localparam int MaxFiresDefault  = 16;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TOK_ZERO   = 2'd0,
    TOK_ARM    = 2'd1,
    TOK_CANCEL = 2'd2,
    TOK_TOP    = 2'd3
  } tok_sel_t;

  // Where a sift hands control back.
  typedef enum logic [1:0] {
    RET_ARM   = 2'd0,
    RET_BUILD = 2'd1,
    RET_POP   = 2'd2,
    RET_REINS = 2'd3
  } ret_t;

  typedef struct packed {
    logic [31:0] tok;
    logic [47:0] exp;
    logic [31:0] ivl;
    logic [15:0] rep;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CHK,
    S_UP_CMP,
    S_UP_WR,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_MOVE_RD,
    S_BUILD,
    S_DN_LD,
    S_DN_LDW,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DN_WR,
    S_TICK_CHK,
    S_TICK_ROOT,
    S_POP_MOVE,
    S_TICK_RE,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load_in;
    logic     rd_parent;
    logic     rd_left;
    logic     rd_right;
    logic     rd_scan;
    logic     rd_last;
    logic     rd_root;
    logic     place;
    logic     up_move;
    logic     dn_move;
    logic     move_last;
    logic     arm_start;
    logic     reins_start;
    logic     dn_load;
    logic     hole_root;
    logic     build_step;
    logic     cancel_hit;
    logic     cap_left;
    logic     cap_right;
    logic     pop;
    logic     scan_clr;
    logic     scan_inc;
    logic     out_load;
    status_t  out_status;
    logic     out_last;
    tok_sel_t out_tok;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  hole_zero;
    logic  parent_gt;
    logic  has_left;
    logic  has_right;
    logic  child_lt;
    logic  scan_done;
    logic  scan_match;
    logic  scan_is_last;
    logic  build_zero;
    logic  cnt_one;
    logic  root_due;
    logic  top_retire;
    logic  found;
    logic  pending;
    logic  out_busy;
  } stat_t;

endpackage : tmhs_pkg
`default_nettype wire

// ----- hdl/tmhs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmhs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tmhs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule : tmhs_ram
`default_nettype wire

// ----- hdl/tmhs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmhs_datapath
// Heap storage, index registers, compare logic and output register.
// ----------------------------------------------------------------------------
module tmhs_datapath #(
  parameter int HeapDepth = 16,
  parameter int MaxFires  = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [1:0]      kind,
  input  wire logic [47:0]     now_ms,
  input  wire logic [31:0]     interval_ms,
  input  wire logic [15:0]     repeat_count,
  input  wire logic [31:0]     cancel_token,
  input  wire tmhs_pkg::cmd_t  cmd,
  output      tmhs_pkg::stat_t stat,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      logic [1:0]      status,
  output      logic [31:0]     token,
  output      logic            last,
  output      logic [47:0]     next_wait_ms
);
  import tmhs_pkg::*;

  localparam int AW = $clog2(HeapDepth);
  localparam int CW = $clog2(HeapDepth + 1);
  localparam int KW = AW + 2;
  localparam int FW = $clog2(MaxFires + 1);

  logic [1:0]  kind_r;
  logic [47:0] now_r;
  logic [31:0] ivl_r;
  logic [15:0] rep_r;
  logic [31:0] ctok_r;

  logic [CW-1:0] cnt;
  logic [31:0]   tok_ctr;
  logic [AW-1:0] hole;
  logic [AW-1:0] child;
  logic [CW-1:0] scan;
  logic [AW-1:0] build;
  logic [FW-1:0] fires;
  logic          found;

  slot_t s_r;     // element being placed
  slot_t a_r;     // smaller child
  slot_t top_r;   // popped timer

  logic [AW-1:0] addr;
  logic          we;
  slot_t         wdata;
  slot_t         rdata;

  tmhs_ram #(.Width($bits(slot_t)), .Depth(HeapDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

  logic [KW-1:0] left_w;
  logic [KW-1:0] right_w;
  logic [AW-1:0] parent_w;
  logic [CW-1:0] last_w;
  logic [47:0]   wait_w;
  assign left_w   = {1'b0, hole, 1'b1};
  assign right_w  = left_w + KW'(1);
  assign parent_w = (hole - AW'(1)) >> 1;
  assign last_w   = cnt - CW'(1);
  assign wait_w   = (cnt == '0 || !(rdata.exp > now_r)) ? 48'd0 : rdata.exp - now_r;

  always_comb begin
    addr  = hole;
    we    = 1'b0;
    wdata = s_r;
    if (cmd.rd_parent) addr = parent_w;
    if (cmd.rd_left)   addr = AW'(left_w);
    if (cmd.rd_right)  addr = AW'(right_w);
    if (cmd.rd_scan)   addr = AW'(scan);
    if (cmd.rd_last)   addr = AW'(last_w);
    if (cmd.rd_root)   addr = '0;
    if (cmd.place)     begin we = 1'b1; addr = hole; wdata = s_r; end
    if (cmd.up_move)   begin we = 1'b1; addr = hole; wdata = rdata; end
    if (cmd.dn_move)   begin we = 1'b1; addr = hole; wdata = a_r; end
    if (cmd.move_last) begin we = 1'b1; addr = AW'(scan); wdata = rdata; end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      now_r  <= now_ms;
      ivl_r  <= interval_ms;
      rep_r  <= repeat_count;
      ctok_r <= cancel_token;
    end
    if (cmd.arm_start) begin
      s_r.tok <= tok_ctr + 32'd1;
      s_r.exp <= sat_add(now_r, ivl_r);
      s_r.ivl <= ivl_r;
      s_r.rep <= rep_r;
    end
    if (cmd.reins_start) begin
      s_r.tok <= top_r.tok;
      s_r.exp <= sat_add(top_r.exp, top_r.ivl);
      s_r.ivl <= top_r.ivl;
      s_r.rep <= (top_r.rep == 16'd0) ? 16'd0 : top_r.rep - 16'd1;
    end
    if (cmd.dn_load) s_r <= rdata;
    if (cmd.arm_start || cmd.reins_start) hole <= AW'(cnt);
    if (cmd.up_move)   hole <= parent_w;
    if (cmd.dn_move)   hole <= child;
    if (cmd.hole_root) hole <= '0;
    if (cmd.build_step) begin
      build <= build - AW'(1);
      hole  <= build - AW'(1);
    end
    if (cmd.cancel_hit) build <= AW'(last_w >> 1);
    if (cmd.cap_left) begin
      a_r   <= rdata;
      child <= AW'(left_w);
    end
    if (cmd.cap_right && (rdata.exp < a_r.exp)) begin
      a_r   <= rdata;
      child <= AW'(right_w);
    end
    if (cmd.pop) top_r <= rdata;
    if (cmd.out_load) begin
      status <= cmd.out_status;
      last   <= cmd.out_last;
      case (cmd.out_tok)
        TOK_ARM:    token <= tok_ctr;
        TOK_CANCEL: token <= ctok_r;
        TOK_TOP:    token <= top_r.tok;
        default:    token <= 32'd0;
      endcase
      next_wait_ms <= wait_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      tok_ctr   <= 32'd1;
      scan      <= '0;
      fires     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.arm_start || cmd.reins_start) cnt <= cnt + CW'(1);
      if (cmd.cancel_hit || cmd.pop) cnt <= cnt - CW'(1);
      if (cmd.arm_start) tok_ctr <= tok_ctr + 32'd1;
      if (cmd.scan_clr) begin
        scan  <= '0;
        found <= 1'b0;
        fires <= '0;
      end
      if (cmd.scan_inc) scan <= scan + CW'(1);
      if (cmd.arm_start || cmd.cancel_hit) found <= 1'b1;
      if (cmd.pop) fires <= fires + FW'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.kind         = kind_t'(kind_r);
    stat.full         = (cnt >= CW'(HeapDepth));
    stat.hole_zero    = (hole == '0);
    stat.parent_gt    = (rdata.exp > s_r.exp);
    stat.has_left     = (left_w < KW'(cnt));
    stat.has_right    = (right_w < KW'(cnt));
    stat.child_lt     = (s_r.exp > a_r.exp);
    stat.scan_done    = (scan >= cnt);
    stat.scan_match   = (rdata.tok == ctok_r);
    stat.scan_is_last = (scan == last_w);
    stat.build_zero   = (build == '0);
    stat.cnt_one      = (cnt == CW'(1));
    stat.root_due     = (cnt != '0) && (fires < FW'(MaxFires)) && !(rdata.exp > now_r);
    stat.top_retire   = (top_r.rep == 16'd1);
    stat.found        = found;
    stat.pending      = (fires != '0);
    stat.out_busy     = out_valid && out_stall;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(token)
      && $stable(last) && $stable(next_wait_ms))) else $error("stalled result changed");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall)) else $error("result overwritten");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HeapDepth)) else $error("heap count out of range");

endmodule : tmhs_datapath
`default_nettype wire

// ----- hdl/tmhs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmhs_ctrl
// Sequencer for arm, cancel and tick operations on the heap.
// ----------------------------------------------------------------------------
module tmhs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire tmhs_pkg::stat_t stat,
  output      tmhs_pkg::cmd_t  cmd
);
  import tmhs_pkg::*;

  state_t state, state_next;
  ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_ARM;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        case (stat.kind)
          KIND_ARM: begin
            if (stat.full) begin
              state_next = S_EMIT_RD;
            end else begin
              cmd.arm_start = 1'b1;
              ret_next      = RET_ARM;
              state_next    = S_UP_CHK;
            end
          end
          KIND_CANCEL: state_next = S_SCAN_CHK;
          KIND_TICK:   state_next = S_TICK_CHK;
          default:     state_next = S_IDLE;
        endcase
      end
      S_UP_CHK: begin
        if (stat.hole_zero) begin
          state_next = S_UP_WR;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.parent_gt) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.place = 1'b1;
        if (ret == RET_ARM) state_next = S_EMIT_RD;
        else state_next = S_TICK_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.scan_done) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.scan_match) begin
          cmd.cancel_hit = 1'b1;
          ret_next       = RET_BUILD;
          if (stat.scan_is_last) begin
            state_next = S_BUILD;
          end else begin
            cmd.rd_last = 1'b1;
            state_next  = S_MOVE_RD;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_CHK;
        end
      end
      S_MOVE_RD: begin
        cmd.move_last = 1'b1;
        state_next    = S_BUILD;
      end
      S_BUILD: begin
        if (stat.build_zero) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.build_step = 1'b1;
          state_next     = S_DN_LD;
        end
      end
      S_DN_LD: begin
        state_next = S_DN_LDW;
      end
      S_DN_LDW: begin
        cmd.dn_load = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.has_left) begin
          cmd.rd_left = 1'b1;
          state_next  = S_DN_L;
        end else begin
          state_next = S_DN_WR;
        end
      end
      S_DN_L: begin
        cmd.cap_left = 1'b1;
        if (stat.has_right) begin
          cmd.rd_right = 1'b1;
          state_next   = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.cap_right = 1'b1;
        state_next    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.child_lt) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_CHK;
        end else begin
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.place = 1'b1;
        if (ret == RET_BUILD) state_next = S_BUILD;
        else state_next = S_TICK_RE;
      end
      S_TICK_CHK: begin
        cmd.rd_root = 1'b1;
        state_next  = S_TICK_ROOT;
      end
      S_TICK_ROOT: begin
        cmd.rd_root = 1'b1;
        if (!(stat.out_busy && (stat.pending || !stat.root_due))) begin
          if (stat.pending) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_OK;
            cmd.out_tok    = TOK_TOP;
            cmd.out_last   = !stat.root_due;
          end
          if (stat.root_due) begin
            cmd.pop  = 1'b1;
            ret_next = RET_POP;
            if (stat.cnt_one) begin
              state_next = S_TICK_RE;
            end else begin
              cmd.rd_root = 1'b0;
              cmd.rd_last = 1'b1;
              state_next  = S_POP_MOVE;
            end
          end else begin
            if (!stat.pending) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_NONE;
              cmd.out_tok    = TOK_ZERO;
              cmd.out_last   = 1'b1;
            end
            state_next = S_IDLE;
          end
        end
      end
      S_POP_MOVE: begin
        cmd.dn_load   = 1'b1;
        cmd.hole_root = 1'b1;
        state_next    = S_DN_CHK;
      end
      S_TICK_RE: begin
        if (stat.top_retire) begin
          state_next = S_TICK_CHK;
        end else begin
          cmd.reins_start = 1'b1;
          ret_next        = RET_REINS;
          state_next      = S_UP_CHK;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_root = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.rd_root = 1'b1;
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
          case (stat.kind)
            KIND_ARM: begin
              cmd.out_status = stat.found ? ST_OK : ST_FULL;
              cmd.out_tok    = stat.found ? TOK_ARM : TOK_ZERO;
            end
            KIND_CANCEL: begin
              cmd.out_status = stat.found ? ST_OK : ST_NOTFOUND;
              cmd.out_tok    = TOK_CANCEL;
            end
            default: begin
              cmd.out_status = ST_NONE;
              cmd.out_tok    = TOK_ZERO;
            end
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> (state == S_IDLE)) else $error("load outside idle");
  a_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (state == S_DECODE)) else $error("decode skipped");

endmodule : tmhs_ctrl
`default_nettype wire

// ----- hdl/timer_min_heap_scheduler_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_unit
// Timer queue held as a binary min-heap in a RAM, one item at a time.
//
// The input channel (in_valid/in_stall) takes arm, cancel and tick items; the
// result channel (out_valid/out_stall) returns one result per arm or cancel
// and one per fired timer on tick (one status-only result when nothing is
// due), with last on the final one. Kind 3 is dropped with no result.
// Each operation walks the heap through the single RAM port, one entry per
// access: arm sifts up, cancel scans the entries and, when the token is found,
// rebuilds the heap bottom-up, and tick pops each fired timer and reinserts
// it unless it retires.
// in_stall stays high until the final result is loaded; the next item is
// taken in the cycle after.
// When the receiver stalls, the result register holds and the sequencer
// waits before loading the next result.
// Reset empties the heap and sets the token counter to one; the heap RAM is
// not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module timer_min_heap_scheduler_unit #(
  parameter int HeapDepth = tmhs_pkg::HeapDepthDefault,
  parameter int MaxFires  = tmhs_pkg::MaxFiresDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [47:0] now_ms,
  input  wire logic [31:0] interval_ms,
  input  wire logic [15:0] repeat_count,
  input  wire logic [31:0] cancel_token,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  status,
  output      logic [31:0] token,
  output      logic        last,
  output      logic [47:0] next_wait_ms
);
  import tmhs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tmhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmhs_datapath #(.HeapDepth(HeapDepth), .MaxFires(MaxFires)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .now_ms       (now_ms),
    .interval_ms  (interval_ms),
    .repeat_count (repeat_count),
    .cancel_token (cancel_token),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .token        (token),
    .last         (last),
    .next_wait_ms (next_wait_ms)
  );

endmodule : timer_min_heap_scheduler_unit
`default_nettype wire

// ----- tb/timer_min_heap_scheduler_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_unit_checker
// Watches both channels of the timer min-heap scheduler, keeps its own heap
// and token counter, predicts the results of every accepted item and checks
// each handed-off result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_min_heap_scheduler_unit_checker #(
  parameter int Depth = tmhs_pkg::HeapDepthDefault,
  parameter int Fires = tmhs_pkg::MaxFiresDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [47:0] now_ms,
  input  logic [31:0] interval_ms,
  input  logic [15:0] repeat_count,
  input  logic [31:0] cancel_token,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [31:0] token,
  input  logic        last,
  input  logic [47:0] next_wait_ms,
  output int          pending,
  output int          errors
);
  import tmhs_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] tok;
    logic        lst;
    logic [47:0] wait_ms;
  } timer_result_t;

  slot_t         heap [Depth];
  int            heap_len;
  logic [31:0]   tok_ctr;
  timer_result_t due_q [$];

  assign pending = due_q.size();

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

  function automatic logic [47:0] wait_for(logic [47:0] now);
    if (heap_len == 0) return '0;
    return (heap[0].exp > now) ? heap[0].exp - now : '0;
  endfunction

  task automatic sift_up(int hole, slot_t s);
    int parent;
    while (hole > 0) begin
      parent = (hole - 1) / 2;
      if (heap[parent].exp > s.exp) begin
        heap[hole] = heap[parent];
        hole = parent;
      end else break;
    end
    heap[hole] = s;
  endtask

  task automatic sift_down(int hole);
    slot_t s;
    int c;
    s = heap[hole];
    while (2 * hole + 1 < heap_len) begin
      c = 2 * hole + 1;
      if (c + 1 < heap_len && heap[c].exp > heap[c + 1].exp) c++;
      if (s.exp > heap[c].exp) begin
        heap[hole] = heap[c];
        hole = c;
      end else break;
    end
    heap[hole] = s;
  endtask

  task automatic push_result(status_t st, logic [31:0] tok, logic lst,
                             logic [47:0] now);
    timer_result_t r;
    r.st = st;
    r.tok = tok;
    r.lst = lst;
    r.wait_ms = wait_for(now);
    due_q.push_back(r);
  endtask

  task automatic predict_item(kind_t k, logic [47:0] now, logic [31:0] ivl,
                              logic [15:0] rep, logic [31:0] ctok);
    slot_t s;
    int i;
    int n;
    bit found;
    case (k)
      KIND_ARM: begin
        if (heap_len >= Depth) begin
          push_result(ST_FULL, '0, 1'b1, now);
        end else begin
          tok_ctr = tok_ctr + 1;
          s.tok = tok_ctr;
          s.exp = sat_sum(now, ivl);
          s.ivl = ivl;
          s.rep = rep;
          heap_len++;
          sift_up(heap_len - 1, s);
          push_result(ST_OK, s.tok, 1'b1, now);
        end
      end
      KIND_CANCEL: begin
        found = 0;
        for (i = 0; i < heap_len; i++) begin
          if (heap[i].tok == ctok) begin
            heap[i] = heap[heap_len - 1];
            heap_len--;
            found = 1;
            break;
          end
        end
        if (found) begin
          for (i = heap_len / 2 - 1; i >= 0; i--) sift_down(i);
          push_result(ST_OK, ctok, 1'b1, now);
        end else begin
          push_result(ST_NOTFOUND, ctok, 1'b1, now);
        end
      end
      KIND_TICK: begin
        n = 0;
        while (n < Fires && heap_len > 0 && heap[0].exp <= now) begin
          s = heap[0];
          heap[0] = heap[heap_len - 1];
          heap_len--;
          if (heap_len > 0) sift_down(0);
          if (s.rep != 16'd1) begin
            s.exp = sat_sum(s.exp, s.ivl);
            if (s.rep != 16'd0) s.rep = s.rep - 1;
            heap_len++;
            sift_up(heap_len - 1, s);
          end
          push_result(ST_OK, s.tok, 1'b0, now);
          n++;
        end
        if (n == 0) push_result(ST_NONE, '0, 1'b1, now);
        else due_q[$].lst = 1'b1;
      end
      default: ;
    endcase
  endtask

  initial begin
    errors = 0;
    heap_len = 0;
    tok_ctr = 32'd1;
  end

  always @(posedge clk) begin
    timer_result_t e;
    if (rst) begin
      heap_len = 0;
      tok_ctr = 32'd1;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d token=%0d", $time, status, token);
          errors++;
        end else begin
          e = due_q.pop_front();
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (token !== e.tok) begin
            $display("%0t: token expected %0d actual %0d", $time, e.tok, token);
            errors++;
          end
          if (last !== e.lst) begin
            $display("%0t: last expected %0d actual %0d", $time, e.lst, last);
            errors++;
          end
          if (next_wait_ms !== e.wait_ms) begin
            $display("%0t: next_wait_ms expected %0d actual %0d", $time, e.wait_ms,
                     next_wait_ms);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_item(kind_t'(kind), now_ms, interval_ms, repeat_count, cancel_token);
    end
  end

endmodule

// ----- tb/timer_min_heap_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler_unit_tb
// Drives arm, cancel and tick items into the timer min-heap scheduler with
// random gaps and result stalls: a directed pass over the corner cases
// (saturation, full heap, unknown tokens, fire limit), then random traffic.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timer_min_heap_scheduler_unit_tb;
  import tmhs_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [47:0] now_ms;
  logic [31:0] interval_ms;
  logic [15:0] repeat_count;
  logic [31:0] cancel_token;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] token;
  logic        last;
  logic [47:0] next_wait_ms;
  int          pending;
  int          errors;
  bit          quiet;
  int          arms_sent;
  logic [47:0] clock_ms;

  timer_min_heap_scheduler_unit u_dut (.*);

  timer_min_heap_scheduler_unit_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk) out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 26);

  task automatic send_item(kind_t k, logic [47:0] now, logic [31:0] ivl,
                           logic [15:0] rep, logic [31:0] ctok);
    while (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    now_ms <= now;
    interval_ms <= ivl;
    repeat_count <= rep;
    cancel_token <= ctok;
    if (k == KIND_ARM) arms_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 40);
    if (r < 90) return $urandom;
    return (r < 95) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic logic [15:0] pick_repeat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'd0;
    if (r < 55) return 16'd1;
    if (r < 85) return $urandom_range(2, 5);
    return (r < 92) ? 16'hFFFF : $urandom;
  endfunction

  initial begin
    int i;
    int r;
    int lo;
    rst = 1'b1;
    quiet = 0;
    in_valid = 1'b0;
    kind = KIND_ARM;
    now_ms = '0;
    interval_ms = '0;
    repeat_count = '0;
    cancel_token = '0;
    out_stall = 1'b0;
    arms_sent = 0;
    clock_ms = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(KIND_TICK, 48'd0, 32'd0, 16'd0, 32'd0);
    send_item(KIND_CANCEL, 48'd0, 32'd0, 16'd0, 32'd2);
    send_item(KIND_ARM, 48'd0, 32'd0, 16'd1, 32'd0);
    send_item(KIND_ARM, 48'd0, 32'hFFFF_FFFF, 16'd0, 32'd0);
    send_item(KIND_ARM, Max48, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_item(KIND_ARM, 48'd5, 32'd3, 16'd2, 32'hFFFF_FFFF);
    send_item(KIND_NONE, Max48, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_TICK, 48'd0, 32'd0, 16'd0, 32'd0);
    send_item(KIND_TICK, 48'd8, 32'd0, 16'd0, 32'd0);
    send_item(KIND_CANCEL, 48'd8, 32'd0, 16'd0, 32'hFFFF_FFFF);
    send_item(KIND_CANCEL, 48'd8, 32'd0, 16'd0, 32'd3);
    for (i = 0; i < 15; i++)
      send_item(KIND_ARM, 48'd10, 32'd0, 16'd0, 32'd0);
    send_item(KIND_TICK, Max48, 32'd0, 16'd0, 32'd0);
    send_item(KIND_TICK, Max48, 32'd0, 16'd0, 32'd0);
    for (i = 0; i <= arms_sent + 2; i++)
      send_item(KIND_CANCEL, 48'd0, 32'd0, 16'd0, i);
    drain();

    for (i = 0; i < 450; i++) begin
      quiet = (i >= 150 && i < 250);
      if (i == 300) drain();
      clock_ms = clock_ms + $urandom_range(0, 20);
      r = $urandom_range(0, 99);
      lo = (arms_sent > 20) ? arms_sent - 20 : 0;
      if (r < 40) begin
        send_item(KIND_ARM, clock_ms, pick_interval(), pick_repeat(), $urandom);
      end else if (r < 65) begin
        send_item(KIND_CANCEL, clock_ms, $urandom, $urandom,
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(lo, arms_sent + 2));
      end else if (r < 97) begin
        send_item(KIND_TICK,
                  ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : clock_ms,
                  $urandom, $urandom, $urandom);
      end else begin
        send_item(KIND_NONE, {$urandom, $urandom}, $urandom, $urandom, $urandom);
        i--;
      end
    end
    quiet = 0;
    drain();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tmhs_pkg.sv
hdl/tmhs_ram.sv
hdl/tmhs_datapath.sv
hdl/tmhs_ctrl.sv
hdl/timer_min_heap_scheduler_unit.sv
tb/timer_min_heap_scheduler_unit_checker.sv
tb/timer_min_heap_scheduler_unit_tb.sv
